// File: hw/rtl/pcmmix_pkg.sv
// Shared constants, request codes and types of the PCM sample mixer.
package pcmmix_pkg;

    // Voice table and sample store sizes
    localparam int VOICES      = 16;
    localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int STORE_AW    = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // Field widths
    localparam int REQ_W     = 3;
    localparam int VOICE_W   = 4;
    localparam int VOL_W     = 7;
    localparam int SEP_W     = 8;
    localparam int ADDR_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int PCM_W     = 16;
    localparam int MASK_W    = 16;
    localparam int STEP_W    = 16;
    localparam int POS_W     = 32;
    localparam int GAIN_W    = 7;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 56;

    // Mix accumulator: music plus every voice at full scale
    localparam int ACC_W = 21;

    // Position step after reset: source rate over output rate in Q0.16
    localparam int SOURCE_HZ = 11025;
    localparam int MIX_HZ    = 48000;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'((SOURCE_HZ * 65536) / MIX_HZ);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd5;

    // Control from the sequencer to the scale and accumulate unit
    typedef struct packed {
        logic                     init;
        logic                     vld;
        logic [GAIN_W-1:0]        gain_l;
        logic [GAIN_W-1:0]        gain_r;
        logic signed [PCM_W-1:0]  music;
    } t_scale_in;

endpackage

// File: hw/rtl/pcmmix_store.sv
// Sample store: byte memory with one write port and a registered read port.
module pcmmix_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [pcmmix_pkg::STORE_AW-1:0] i_wr_addr,
    input  logic [pcmmix_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [pcmmix_pkg::STORE_AW-1:0] i_rd_addr,
    output logic [pcmmix_pkg::BYTE_W-1:0] o_rd_data
);
    import pcmmix_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Write a loaded byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/pcmmix_gain.sv
// Pan law: left and right gains from volume and separation, divided by 255.
module pcmmix_gain (
    input  logic [pcmmix_pkg::VOL_W-1:0]  i_volume,
    input  logic [pcmmix_pkg::SEP_W-1:0]  i_separation,
    output logic [pcmmix_pkg::GAIN_W-1:0] o_gain_l,
    output logic [pcmmix_pkg::GAIN_W-1:0] o_gain_r
);
    import pcmmix_pkg::*;

    localparam logic [SEP_W-1:0] SEP_FULL = 8'd255;

    // Exact x/255 for x up to 127*255, the largest product here: (x + (x >> 8) + 1) >> 8
    function automatic logic [GAIN_W-1:0] div255(input logic [15:0] x);
        logic [15:0] s;
        s = x + {8'd0, x[15:8]} + 16'd1;
        return s[GAIN_W+7:8];
    endfunction

    logic [SEP_W-1:0] w_sep_l;
    logic [15:0]      w_prod_l;
    logic [15:0]      w_prod_r;

    // Scale volume by the share of each side
    assign w_sep_l  = SEP_FULL - i_separation;
    assign w_prod_l = 16'(i_volume * w_sep_l);
    assign w_prod_r = 16'(i_volume * i_separation);

    assign o_gain_l = div255(w_prod_l);
    assign o_gain_r = div255(w_prod_r);

endmodule

// File: hw/rtl/pcmmix_scale.sv
// Shared scale unit: voice sample times gain over 127, accumulated per side.
module pcmmix_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcmmix_pkg::t_scale_in               i_ctl,
    input  logic [pcmmix_pkg::BYTE_W-1:0]       i_byte,
    output logic signed [pcmmix_pkg::ACC_W-1:0] o_acc_l,
    output logic signed [pcmmix_pkg::ACC_W-1:0] o_acc_r,
    output logic                                o_busy
);
    import pcmmix_pkg::*;

    localparam int LANES = 2;
    localparam logic [15:0] DIVISOR = 16'd127;

    logic [GAIN_W-1:0]        w_gain [LANES];
    logic signed [7:0]        w_d;

    // Stage registers
    logic                     r_v2;
    logic                     r_v3;
    logic signed [15:0]       r_p   [LANES];
    logic [14:0]              r_x   [LANES];
    logic [7:0]               r_qe  [LANES];
    logic                     r_neg [LANES];
    logic signed [ACC_W-1:0]  r_acc [LANES];

    // Stage logic per lane
    logic signed [15:0]       w_p   [LANES];
    logic [15:0]              w_m   [LANES];
    logic [14:0]              w_x   [LANES];
    logic [14:0]              w_qs  [LANES];
    logic [15:0]              w_r   [LANES];
    logic [8:0]               w_qd  [LANES];
    logic [15:0]              w_mag [LANES];
    logic signed [16:0]       w_val [LANES];

    assign w_gain[0] = i_ctl.gain_l;
    assign w_gain[1] = i_ctl.gain_r;

    // Centered voice byte: byte - 128 as a signed byte
    assign w_d = signed'({~i_byte[7], i_byte[6:0]});

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            // Product of centered byte and gain
            w_p[l]  = 16'(w_d * $signed({1'b0, w_gain[l]}));
            // Magnitude times 256 over 127 = 2m + 2m/127; estimate 2m/127 low by at most one
            w_m[l]  = r_p[l][15] ? 16'(-r_p[l]) : 16'(r_p[l]);
            w_x[l]  = {w_m[l][13:0], 1'b0};
            w_qs[l] = w_x[l] + {7'd0, w_x[l][14:7]};
            // Correct the estimate with one remainder compare
            w_r[l]   = {1'b0, r_x[l]} - {1'b0, r_qe[l], 7'd0} + {8'd0, r_qe[l]};
            w_qd[l]  = {1'b0, r_qe[l]} + 9'(w_r[l] >= DIVISOR);
            w_mag[l] = {1'b0, r_x[l]} + {7'd0, w_qd[l]};
            w_val[l] = r_neg[l] ? -$signed({1'b0, w_mag[l]}) : $signed({1'b0, w_mag[l]});
        end
    end

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.vld;
            r_v3 <= r_v2;
        end
    end

    // Stage data and accumulators
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_ctl.vld) begin
                r_p[l] <= w_p[l];
            end
            if (r_v2) begin
                r_x[l]   <= w_x[l];
                r_qe[l]  <= w_qs[l][14:7];
                r_neg[l] <= r_p[l][15];
            end
            if (i_ctl.init) begin
                r_acc[l] <= ACC_W'(i_ctl.music);
            end else if (r_v3) begin
                r_acc[l] <= r_acc[l] + ACC_W'(w_val[l]);
            end
        end
    end

    assign o_acc_l = r_acc[0];
    assign o_acc_r = r_acc[1];
    assign o_busy  = r_v2 | r_v3;

endmodule

// File: hw/rtl/multichannel_pcm_mixer.sv
// Non-tick requests: executed once, then the result is loaded in the finish step when the output is free.
// Tick: one voice per cycle through the shared scale unit, then a drain until it empties;
// the result is loaded in the finish step when the output is free. A new transaction is
// accepted only in idle, after the previous result has been loaded into the output register.
// Synchronous active-low reset clears active bits, sequencer and valids, restores the step;
// the sample store and voice parameters keep their contents.
module multichannel_pcm_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [pcmmix_pkg::STEP_W-1:0]       i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // voice, volume, separation, address, sample_count, sample_byte, music_sample, zero pad
    input  logic [pcmmix_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [pcmmix_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // left_out, right_out, status, voice_playing, active_mask, zero pad
    output logic [pcmmix_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import pcmmix_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_TICK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam int VX_W = VIDX_W + VOICE_W;
    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    function automatic logic [PCM_W-1:0] sat16(input logic signed [ACC_W-1:0] a);
        logic [PCM_W-1:0] res;
        if (a > SAT_MAX) begin
            res = SAT_MAX[PCM_W-1:0];
        end else if (a < SAT_MIN) begin
            res = SAT_MIN[PCM_W-1:0];
        end else begin
            res = a[PCM_W-1:0];
        end
        return res;
    endfunction

    // Input fields
    logic [VOICE_W-1:0] w_in_voice;
    logic [VX_W-1:0]    w_in_vx;
    logic               w_in_accept;

    assign w_in_voice  = s_axis_tdata[3:0];
    assign w_in_vx     = {{VIDX_W{1'b0}}, w_in_voice};
    assign w_in_accept = s_axis_tvalid & s_axis_tready;

    // Captured request
    logic [REQ_W-1:0]        r_req_type;
    logic [VIDX_W-1:0]       r_req_idx;
    logic                    r_req_ok;
    logic [VOL_W-1:0]        r_req_vol;
    logic [SEP_W-1:0]        r_req_sep;
    logic [ADDR_W-1:0]       r_req_addr;
    logic [COUNT_W-1:0]      r_req_cnt;
    logic [BYTE_W-1:0]       r_req_byte;
    logic signed [PCM_W-1:0] r_req_music;

    // Sequencer and control state
    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [VIDX_W-1:0]       r_cnt;
    logic [VOICES-1:0]       r_active;
    logic [STEP_W-1:0]       r_step;
    logic                    r_s1_vld;
    logic [GAIN_W-1:0]       r_s1_gl;
    logic [GAIN_W-1:0]       r_s1_gr;
    logic                    r_res_status;
    logic                    r_res_play;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    // Voice table
    logic [ADDR_W-1:0]       r_base [VOICES];
    logic [COUNT_W-1:0]      r_len  [VOICES];
    logic [POS_W-1:0]        r_pos  [VOICES];
    logic [GAIN_W-1:0]       r_gl   [VOICES];
    logic [GAIN_W-1:0]       r_gr   [VOICES];

    // Datapath wires
    logic [GAIN_W-1:0]       w_gain_l;
    logic [GAIN_W-1:0]       w_gain_r;
    logic [POS_W-1:0]        w_cur_pos;
    logic [COUNT_W-1:0]      w_cur_idx;
    logic                    w_hit;
    logic                    w_ended;
    logic [ADDR_W:0]         w_sum;
    logic [BYTE_W-1:0]       w_rd_data;
    logic                    w_wr_en;
    t_scale_in               w_sc;
    logic signed [ACC_W-1:0] w_acc_l;
    logic signed [ACC_W-1:0] w_acc_r;
    logic                    w_busy;
    logic                    w_out_free;
    logic [MASK_W-1:0]       w_mask;
    logic [PCM_W-1:0]        w_left;
    logic [PCM_W-1:0]        w_right;
    logic                    w_exec;
    logic                    w_start_ok;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_exec        = (r_state == ST_EXEC);
    assign w_start_ok    = (r_req_cnt != '0) && r_req_ok;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Capture the request on acceptance
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req_type  <= s_axis_tuser;
            r_req_idx   <= w_in_vx[VIDX_W-1:0];
            r_req_ok    <= (w_in_vx < VX_W'(VOICES));
            r_req_vol   <= s_axis_tdata[10:4];
            r_req_sep   <= s_axis_tdata[18:11];
            r_req_addr  <= s_axis_tdata[34:19];
            r_req_cnt   <= s_axis_tdata[50:35];
            r_req_byte  <= s_axis_tdata[58:51];
            r_req_music <= s_axis_tdata[74:59];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (r_req_type == REQ_TICK) ? ST_TICK : ST_FIN;
            end
            ST_TICK: begin
                if (r_cnt == LAST_VOICE) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !w_busy) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Current voice of the tick pass
    assign w_cur_pos = r_pos[r_cnt];
    assign w_cur_idx = w_cur_pos[POS_W-1:POS_W-COUNT_W];
    assign w_hit     = (r_state == ST_TICK) && r_active[r_cnt] && (w_cur_idx < r_len[r_cnt]);
    assign w_ended   = (r_state == ST_TICK) && r_active[r_cnt] && (w_cur_idx >= r_len[r_cnt]);
    assign w_sum     = {1'b0, r_base[r_cnt]} + {1'b0, w_cur_idx};

    // Sequencer, active bits, step and pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_active <= '0;
            r_step   <= STEP_RESET;
            r_s1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= w_hit;
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            if (r_state == ST_TICK) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_exec && r_req_type == REQ_START && w_start_ok) begin
                r_active[r_req_idx] <= 1'b1;
            end
            if (w_exec && r_req_type == REQ_STOP && r_req_ok) begin
                r_active[r_req_idx] <= 1'b0;
            end
            // Drop a voice whose index has reached its length
            if (w_ended) begin
                r_active[r_cnt] <= 1'b0;
            end
        end
    end

    // Voice parameters and position advance
    always_ff @(posedge i_clk) begin
        if (w_exec && r_req_type == REQ_START && w_start_ok) begin
            r_base[r_req_idx] <= r_req_addr;
            r_len[r_req_idx]  <= r_req_cnt;
            r_pos[r_req_idx]  <= '0;
        end
        if (w_exec && r_req_ok &&
            (r_req_type == REQ_UPDATE || (r_req_type == REQ_START && r_req_cnt != '0))) begin
            r_gl[r_req_idx] <= w_gain_l;
            r_gr[r_req_idx] <= w_gain_r;
        end
        if (w_hit) begin
            r_pos[r_cnt] <= w_cur_pos + {{(POS_W-STEP_W){1'b0}}, r_step};
        end
        r_s1_gl <= r_gl[r_cnt];
        r_s1_gr <= r_gr[r_cnt];
    end

    // Per-item status flags
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_res_status <= (r_req_type == REQ_START) && (r_req_cnt == '0);
            r_res_play   <= (r_req_type == REQ_QUERY) && r_req_ok && r_active[r_req_idx];
        end
    end

    pcmmix_gain u_gain (
        .i_volume     (r_req_vol),
        .i_separation (r_req_sep),
        .o_gain_l     (w_gain_l),
        .o_gain_r     (w_gain_r)
    );

    assign w_wr_en = w_exec && (r_req_type == REQ_LOAD);

    pcmmix_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_req_addr[STORE_AW-1:0]),
        .i_wr_data (r_req_byte),
        .i_rd_en   (w_hit),
        .i_rd_addr (w_sum[STORE_AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_sc.init   = w_exec && (r_req_type == REQ_TICK);
        w_sc.vld    = r_s1_vld;
        w_sc.gain_l = r_s1_gl;
        w_sc.gain_r = r_s1_gr;
        w_sc.music  = r_req_music;
    end

    pcmmix_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sc),
        .i_byte  (w_rd_data),
        .o_acc_l (w_acc_l),
        .o_acc_r (w_acc_r),
        .o_busy  (w_busy)
    );

    // Active mask over the first voices
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < VOICES) begin : g_on
            assign w_mask[b] = r_active[b];
        end else begin : g_off
            assign w_mask[b] = 1'b0;
        end
    end

    assign w_left  = (r_req_type == REQ_TICK) ? sat16(w_acc_l) : '0;
    assign w_right = (r_req_type == REQ_TICK) ? sat16(w_acc_r) : '0;

    // Output register: load on finish, drop once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_out_data <= {6'd0, w_mask, r_res_play, r_res_status, w_right, w_left};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // A new result appears only from the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result raised outside finish step");

    // The mix is read only after the scale pipeline has emptied
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (!w_busy && !r_s1_vld))
        else $error("finish while scale unit busy");

    // Drain leads only to finish
    a_drain_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_DRAIN || r_state == ST_FIN))
        else $error("bad exit from drain");

    // A valid start leaves the voice active
    a_start_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_req_type == REQ_START && w_start_ok) |=> r_active[r_req_idx])
        else $error("start did not activate voice");

    // Store reads happen only during the voice pass
    a_read_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> ($past(r_state) == ST_TICK))
        else $error("store read outside voice pass");
`endif

endmodule

// File: sim/multichannel_pcm_mixer_test.sv
// Testbench of the PCM sample mixer: directed and random requests against a behavioral mixer.
module multichannel_pcm_mixer_test;
    import pcmmix_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP      = 60;
    localparam int MAX_PRINTS   = 40;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // One request as it travels on the slave side
    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [VOICE_W-1:0]        voice;
        logic [VOL_W-1:0]          volume;
        logic [SEP_W-1:0]          pan;
        logic [ADDR_W-1:0]         addr;
        logic [COUNT_W-1:0]        count;
        logic [BYTE_W-1:0]         pcm_byte;
        logic signed [PCM_W-1:0]   music;
    } t_mix_req;

    // One result as it travels on the master side
    typedef struct {
        logic signed [PCM_W-1:0]   left;
        logic signed [PCM_W-1:0]   right;
        logic                      rejected;
        logic                      playing;
        logic [MASK_W-1:0]         mask;
    } t_mix_res;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [STEP_W-1:0]       i_cfg_wr_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [REQ_W-1:0]        s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    // Behavioral mixer state
    bit [7:0]                pcm_store [0:STORE_DEPTH-1];
    bit                      store_written [0:STORE_DEPTH-1];
    logic [VOICES-1:0]       voice_on = '0;
    logic [ADDR_W-1:0]       voice_base [0:VOICES-1];
    logic [COUNT_W-1:0]      voice_len [0:VOICES-1];
    logic [POS_W-1:0]        voice_pos [0:VOICES-1];
    logic [GAIN_W-1:0]       gain_l [0:VOICES-1];
    logic [GAIN_W-1:0]       gain_r [0:VOICES-1];
    logic [STEP_W-1:0]       step_q16 = STEP_RESET;

    t_mix_res                expected_mix [$];
    int                      error_count = 0;
    int                      cycle_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;

    multichannel_pcm_mixer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_mix.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the master side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_mix_res got;
        t_mix_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.left     = m_axis_tdata[15:0];
            got.right    = m_axis_tdata[31:16];
            got.rejected = m_axis_tdata[32];
            got.playing  = m_axis_tdata[33];
            got.mask     = m_axis_tdata[49:34];
            if (expected_mix.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_mix.pop_front();
                check_field("left_out", int'(got.left), int'(want.left));
                check_field("right_out", int'(got.right), int'(want.right));
                check_field("status", int'(got.rejected), int'(want.rejected));
                check_field("voice_playing", int'(got.playing), int'(want.playing));
                check_field("active_mask", int'(got.mask), int'(want.mask));
            end
        end
    end

    function automatic logic signed [PCM_W-1:0] saturate_pcm(input int acc);
        if (acc > 32767)
            return 16'sd32767;
        if (acc < -32768)
            return -16'sd32768;
        return acc[PCM_W-1:0];
    endfunction

    function automatic void set_pan_gains(input logic [VOICE_W-1:0] v, input int vol,
                                          input int pan);
        gain_l[v] = GAIN_W'((vol * (255 - pan)) / 255);
        gain_r[v] = GAIN_W'((vol * pan) / 255);
    endfunction

    // Apply one request to the behavioral mixer and return its result
    function automatic t_mix_res mix_predict(input t_mix_req r);
        t_mix_res res;
        int acc_l;
        int acc_r;
        int pcm;
        int c;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] a;
        res.left = '0;
        res.right = '0;
        res.rejected = 1'b0;
        res.playing = 1'b0;
        case (r.kind)
            REQ_TICK: begin
                acc_l = int'(r.music);
                acc_r = int'(r.music);
                for (c = 0; c < VOICES; c++) begin
                    if (voice_on[c]) begin
                        idx = voice_pos[c][31:16];
                        if (idx >= voice_len[c]) begin
                            voice_on[c] = 1'b0;
                        end else begin
                            a = voice_base[c] + idx;
                            pcm = (int'(pcm_store[a]) - 128) * 256;
                            acc_l += (pcm * int'(gain_l[c])) / 127;
                            acc_r += (pcm * int'(gain_r[c])) / 127;
                            voice_pos[c] = voice_pos[c] + POS_W'(step_q16);
                        end
                    end
                end
                res.left = saturate_pcm(acc_l);
                res.right = saturate_pcm(acc_r);
            end
            REQ_LOAD: begin
                pcm_store[r.addr] = r.pcm_byte;
                store_written[r.addr] = 1'b1;
            end
            REQ_START: begin
                if (r.count == 0) begin
                    res.rejected = 1'b1;
                end else begin
                    voice_base[r.voice] = r.addr;
                    voice_len[r.voice] = r.count;
                    voice_pos[r.voice] = '0;
                    set_pan_gains(r.voice, int'(r.volume), int'(r.pan));
                    voice_on[r.voice] = 1'b1;
                end
            end
            REQ_UPDATE: set_pan_gains(r.voice, int'(r.volume), int'(r.pan));
            REQ_STOP:   voice_on[r.voice] = 1'b0;
            REQ_QUERY:  res.playing = voice_on[r.voice];
            default: ;
        endcase
        res.mask = voice_on[MASK_W-1:0];
        return res;
    endfunction

    // Set the request code, and fill every other field at random
    function automatic t_mix_req rand_req(input logic [REQ_W-1:0] kind);
        t_mix_req r;
        r.kind     = kind;
        r.voice    = VOICE_W'($urandom_range(VOICES - 1));
        r.volume   = VOL_W'($urandom_range(127));
        r.pan      = SEP_W'($urandom_range(255));
        r.addr     = ADDR_W'($urandom_range(65535));
        r.count    = COUNT_W'($urandom_range(65535));
        r.pcm_byte = BYTE_W'($urandom_range(255));
        r.music    = PCM_W'($urandom_range(65535));
        return r;
    endfunction

    function automatic t_mix_req make_req(input logic [REQ_W-1:0] kind, input int voice,
                                          input int volume, input int pan, input int addr,
                                          input int count, input int pcm_byte,
                                          input int music);
        t_mix_req r;
        r.kind     = kind;
        r.voice    = VOICE_W'(voice);
        r.volume   = VOL_W'(volume);
        r.pan      = SEP_W'(pan);
        r.addr     = ADDR_W'(addr);
        r.count    = COUNT_W'(count);
        r.pcm_byte = BYTE_W'(pcm_byte);
        r.music    = PCM_W'(music);
        return r;
    endfunction

    // Drive one request transaction and record its expected result on acceptance
    task automatic send_item(input t_mix_req r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {5'b0, r.music, r.pcm_byte, r.count, r.addr, r.pan, r.volume,
                          r.voice};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_mix.push_back(mix_predict(r));
    endtask

    // Load any byte the coming tick reads that was never written, then tick
    task automatic send_tick(input int music);
        int c;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] a;
        for (c = 0; c < VOICES; c++) begin
            idx = voice_pos[c][31:16];
            a = voice_base[c] + idx;
            if (voice_on[c] && idx < voice_len[c] && !store_written[a])
                send_item(make_req(REQ_LOAD, $urandom_range(15), $urandom_range(127),
                                   $urandom_range(255), int'(a), $urandom_range(65535),
                                   $urandom_range(255), $urandom_range(65535)));
        end
        send_item(make_req(REQ_TICK, $urandom_range(15), $urandom_range(127),
                           $urandom_range(255), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(255), music));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_mix.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 88 : (mode == IDLE_BOTH) ? 10 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 88 : (mode == IDLE_BOTH) ? 10 : 0;
    endtask

    // Write the step register once the mixer is idle
    task automatic write_step(input logic [STEP_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        step_q16 = value;
    endtask

    function automatic int pick_addr();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(511);
        if (sel < 90)
            return $urandom_range(65535, 65024);
        return $urandom_range(65535);
    endfunction

    function automatic int pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return 0;
        if (sel < 84)
            return $urandom_range(48, 1);
        if (sel < 94)
            return $urandom_range(4000, 49);
        if (sel < 97)
            return 65535;
        return $urandom_range(65535);
    endfunction

    function automatic int pick_music();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 32767;
        if (sel < 10)
            return -32768;
        if (sel < 40)
            return $signed(16'($urandom_range(65535)));
        return $urandom_range(2000) - 1000;
    endfunction

    // Send one random request, weighted toward playing voices and ticks
    task automatic send_random_item();
        t_mix_req r;
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            send_tick(pick_music());
        end else begin
            r = rand_req(REQ_QUERY);
            if (sel < 58) begin
                r.kind = REQ_LOAD;
                r.addr = ADDR_W'(pick_addr());
            end else if (sel < 73) begin
                r.kind = REQ_START;
                r.addr = ADDR_W'(pick_addr());
                r.count = COUNT_W'(pick_count());
            end else if (sel < 81) begin
                r.kind = REQ_UPDATE;
            end else if (sel < 88) begin
                r.kind = REQ_STOP;
            end
            send_item(r);
        end
    endtask

    task automatic test_random_mix(input int n, input t_idle_mode mode);
        int i;
        set_idle(mode);
        for (i = 0; i < n; i++)
            send_random_item();
    endtask

    // Extremes, every request code, wrap, saturation, rejection and end of sound
    task automatic test_directed();
        int i;
        set_idle(IDLE_NONE);
        send_item(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
        send_tick(32767);
        send_tick(-32768);
        send_item(make_req(REQ_START, 3, 127, 255, 65535, 0, 255, 0));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 65535, 0, 255, 0));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 1, 0, 255, 0));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 2, 0, 128, 0));
        send_item(make_req(REQ_START, 15, 127, 0, 65535, 3, 0, 0));
        send_item(make_req(REQ_START, 0, 127, 255, 65535, 65535, 0, 0));
        send_item(make_req(REQ_QUERY, 15, 0, 0, 0, 0, 0, 0));
        send_tick(32767);
        send_item(make_req(REQ_START, 1, 127, 128, 0, 1, 0, 0));
        send_tick(-32768);
        send_item(make_req(REQ_UPDATE, 15, 64, 128, 0, 0, 0, 0));
        send_item(make_req(REQ_UPDATE, 7, 127, 200, 0, 0, 0, 0));
        send_item(make_req(REQ_STOP, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_STOP, 9, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_req(REQ_START, 5, 0, 128, 2, 1, 0, 0));
        for (i = 0; i < 6; i++)
            send_tick(0);
    endtask

    // Hold the sender until every expected result has come, then resume
    task automatic test_pause_until_drained();
        set_idle(IDLE_BOTH);
        test_random_mix(25, IDLE_BOTH);
        wait_drained();
        test_random_mix(25, IDLE_BOTH);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(250, IDLE_NONE);
        write_step(16'd65535);
        test_random_mix(200, IDLE_SEND);
        write_step(16'd1);
        test_random_mix(200, IDLE_RECV);
        test_pause_until_drained();
        write_step(STEP_W'($urandom_range(65534, 2)));
        test_random_mix(150, IDLE_BOTH);
        write_step(STEP_RESET);
        test_random_mix(200, IDLE_NONE);

        wait_drained();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
